// ===== hw/rtl/lc3_pkg.sv =====
// Shared types and constants for the LC-3 processor core.
// Used by the controller, the datapath and the top level; no dependencies.
package lc3_pkg;

    localparam int ADDR_BITS_DEFAULT = 16;
    localparam logic [15:0] PC_RESET  = 16'h3000;
    localparam logic [15:0] KBSR_ADDR = 16'hFE00;
    localparam logic [15:0] KBDR_ADDR = 16'hFE02;
    localparam logic [15:0] KEY_READY = 16'h8000;

    localparam logic [7:0] VEC_GETC = 8'h20;
    localparam logic [7:0] VEC_OUT  = 8'h21;
    localparam logic [7:0] VEC_IN   = 8'h23;   // not served, only links R7
    localparam logic [7:0] VEC_HALT = 8'h25;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_WAITKEY = 2'd3;

    typedef enum logic [3:0] {
        OP_BR = 4'd0, OP_ADD = 4'd1, OP_LD = 4'd2, OP_ST = 4'd3,
        OP_JSR = 4'd4, OP_AND = 4'd5, OP_LDR = 4'd6, OP_STR = 4'd7,
        OP_RTI = 4'd8, OP_NOT = 4'd9, OP_LDI = 4'd10, OP_STI = 4'd11,
        OP_JMP = 4'd12, OP_RES = 4'd13, OP_LEA = 4'd14, OP_TRAP = 4'd15
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_IND, S_MEM, S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic do_load;      // write load word, reset pc
        logic halt_reply;   // build halted reply
        logic fetch;        // read instruction at pc
        logic exec;         // decode ir, first memory access / register work
        logic ind;          // second indirect access (LDI/STI)
        logic mem;          // final data access result
        logic finish;       // register reply
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic halted;
        logic need_ind;
        logic need_mem;
    } dp_stat_t;

    function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
        logic [15:0] r;
        r = v;
        for (int i = 0; i < 16; i++) begin
            if (i >= bits) r[i] = v[bits-1];
        end
        return r;
    endfunction

    function automatic logic [2:0] flags_of(input logic [15:0] x);
        if (x == 16'd0) return 3'b010;
        else if (x[15]) return 3'b100;
        else return 3'b001;
    endfunction

endpackage

// ===== hw/rtl/lc3_ctrl.sv =====
// Sequencer for the LC-3 core: steps each item through fetch, execute and
// memory phases (a load through its load phase). Depends on lc3_pkg.
module lc3_ctrl import lc3_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_cmd,
    output logic     s_ready,
    input  logic     m_busy,
    output logic     m_load,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_load     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = !m_busy;
                if (s_valid && !m_busy) begin
                    if (!s_cmd) state_next = S_LOAD;
                    else if (stat.halted) begin
                        cmd.halt_reply = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        cmd.fetch = 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_LOAD: begin
                cmd.do_load = 1'b1;
                state_next  = S_DONE;
            end
            S_FETCH: state_next = S_EXEC;
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.need_ind)      state_next = S_IND;
                else if (stat.need_mem) state_next = S_MEM;
                else                    state_next = S_DONE;
            end
            S_IND: begin
                cmd.ind = 1'b1;
                state_next = S_MEM;
            end
            S_MEM: begin
                cmd.mem = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                m_load     = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/lc3_dp.sv =====
// Datapath of the LC-3 core: word memory, register file, pc, flags, reply.
// Depends on lc3_pkg; driven by lc3_ctrl commands.
module lc3_dp import lc3_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic        in_take,
    input  logic [15:0] in_addr,
    input  logic [15:0] in_data,
    input  logic        in_key_valid,
    input  logic [7:0]  in_key_char,
    input  logic [15:0] start_address,
    output logic [1:0]  r_status,
    output logic        r_out_valid,
    output logic [7:0]  r_out_char,
    output logic [15:0] r_pc,
    output logic [2:0]  r_flags
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, ir_reg, rd_reg, at_reg, addr_reg;
    logic [15:0] ld_addr_reg, ld_data_reg;
    logic        key_ok_reg;
    logic [7:0]  key_val_reg;
    logic [2:0]  cond_reg;
    logic        halted_reg;
    logic [1:0]  status_reg;
    logic        ov_reg;
    logic [7:0]  oc_reg;
    logic        kb_hit_reg;

    // memory port controls
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [15:0]          mem_wdata;
    logic                 rd_kbsr;

    // key offered by the item: taken straight from the input on the fetch cycle
    logic                 key_ok_now;
    logic [7:0]           key_val_now;

    opcode_t     op;
    logic [2:0]  dr, sr;
    logic [15:0] pc1, off9, off6, srv, drv, bval, alu;

    assign key_ok_now  = in_take ? in_key_valid : key_ok_reg;
    assign key_val_now = in_take ? in_key_char : key_val_reg;

    assign op   = opcode_t'(ir_reg[15:12]);
    assign dr   = ir_reg[11:9];
    assign sr   = ir_reg[8:6];
    assign pc1  = at_reg + 16'd1;
    assign off9 = sext(ir_reg, 9);
    assign off6 = sext(ir_reg, 6);
    assign srv  = rf_reg[sr];
    assign drv  = rf_reg[dr];
    assign bval = ir_reg[5] ? sext(ir_reg, 5) : rf_reg[ir_reg[2:0]];

    // data value as seen through the keyboard registers
    logic [15:0] rdata;
    always_comb begin
        rdata = rd_reg;
        if (kb_hit_reg) rdata = key_ok_reg ? KEY_READY : 16'd0;
    end

    logic [15:0] mem_addr_exec;
    always_comb begin
        case (op)
            OP_LDR, OP_STR: mem_addr_exec = srv + off6;
            default:        mem_addr_exec = pc1 + off9;
        endcase
    end

    assign stat.halted   = halted_reg;
    assign stat.need_ind = (op == OP_LDI) || (op == OP_STI);
    assign stat.need_mem = (op == OP_LD) || (op == OP_LDR);

    // memory port: one read and at most one write a cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ld_addr_reg[ADDR_BITS-1:0];
        mem_wdata = ld_data_reg;
        mem_raddr = pc_reg[ADDR_BITS-1:0];
        rd_kbsr   = 1'b0;
        if (cmd.do_load) begin
            mem_we = 1'b1;
        end else if (cmd.fetch) begin
            rd_kbsr = (pc_reg == KBSR_ADDR);
        end else if (cmd.exec) begin
            mem_raddr = mem_addr_exec[ADDR_BITS-1:0];
            rd_kbsr   = (mem_addr_exec == KBSR_ADDR) &&
                        (op == OP_LD || op == OP_LDR || op == OP_LDI || op == OP_STI);
            if (op == OP_ST || op == OP_STR) begin
                mem_we    = 1'b1;
                mem_waddr = mem_addr_exec[ADDR_BITS-1:0];
                mem_wdata = drv;
            end
        end else if (cmd.ind) begin
            mem_raddr = rdata[ADDR_BITS-1:0];
            if (op == OP_LDI) rd_kbsr = (rdata == KBSR_ADDR);
            else begin
                mem_we    = 1'b1;
                mem_waddr = rdata[ADDR_BITS-1:0];
                mem_wdata = drv;
            end
        end
    end

    // keyboard refresh writes go through the same port on read cycles
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        else if (rd_kbsr && key_ok_now) mem[KBDR_ADDR[ADDR_BITS-1:0]] <= {8'd0, key_val_now};
        rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) kb_hit_reg <= 1'b0;
        else          kb_hit_reg <= rd_kbsr;
    end

    always_comb begin
        case (op)
            OP_ADD:  alu = srv + bval;
            OP_AND:  alu = srv & bval;
            OP_NOT:  alu = ~srv;
            default: alu = pc1 + off9;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            ld_addr_reg <= in_addr;
            ld_data_reg <= in_data;
            key_ok_reg  <= in_key_valid;
            key_val_reg <= in_key_char;
        end
        if (cmd.fetch) begin
            at_reg <= pc_reg;
            ov_reg <= 1'b0;
            oc_reg <= 8'd0;
        end
        if (cmd.do_load || cmd.halt_reply) begin
            ov_reg <= 1'b0;
            oc_reg <= 8'd0;
        end
        if (cmd.exec && op == OP_TRAP && ir_reg[7:0] == VEC_OUT) begin
            ov_reg <= 1'b1;
            oc_reg <= rf_reg[0][7:0];
        end
    end

    // instruction register grabs the fetched word
    logic ir_load_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) ir_load_reg <= 1'b0;
        else          ir_load_reg <= cmd.fetch;
        if (ir_load_reg) ir_reg <= rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) rf_reg[i] <= 16'd0;
            pc_reg     <= PC_RESET;
            cond_reg   <= 3'd0;
            halted_reg <= 1'b0;
            status_reg <= ST_OK;
        end else begin
            if (cmd.do_load) begin
                pc_reg     <= start_address;
                halted_reg <= 1'b0;
                status_reg <= ST_OK;
            end
            if (cmd.halt_reply) status_reg <= ST_HALTED;
            if (cmd.fetch) status_reg <= ST_OK;
            if (cmd.exec) begin
                pc_reg <= pc1;
                case (op)
                    OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
                        rf_reg[dr] <= alu;
                        cond_reg   <= flags_of(alu);
                    end
                    OP_BR:  if ((dr & cond_reg) != 3'd0) pc_reg <= pc1 + off9;
                    OP_JMP: pc_reg <= srv;
                    OP_JSR: begin
                        rf_reg[7] <= pc1;
                        pc_reg <= ir_reg[11] ? pc1 + sext(ir_reg, 11) : srv;
                    end
                    OP_TRAP: begin
                        if (ir_reg[7:0] == VEC_GETC) begin
                            if (!key_ok_reg) begin
                                status_reg <= ST_WAITKEY;
                                pc_reg     <= at_reg;
                            end else begin
                                rf_reg[7] <= pc1;
                                rf_reg[0] <= {8'd0, key_val_reg};
                                cond_reg  <= flags_of({8'd0, key_val_reg});
                            end
                        end else begin
                            rf_reg[7] <= pc1;
                            if (ir_reg[7:0] == VEC_HALT) begin
                                halted_reg <= 1'b1;
                                status_reg <= ST_HALTED;
                            end
                        end
                    end
                    OP_RTI, OP_RES: begin
                        halted_reg <= 1'b1;
                        status_reg <= ST_ILLEGAL;
                    end
                    default: ;
                endcase
            end
            if (cmd.mem && (op == OP_LD || op == OP_LDR || op == OP_LDI)) begin
                rf_reg[dr] <= rdata;
                cond_reg   <= flags_of(rdata);
            end
        end
    end

    assign r_status    = status_reg;
    assign r_out_valid = ov_reg;
    assign r_out_char  = oc_reg;
    assign r_pc        = pc_reg;
    assign r_flags     = cond_reg;

endmodule

// ===== hw/rtl/lc3_processor_core.sv =====
// LC-3 processor core top level: stream ports, config register, output
// register. Depends on lc3_pkg, lc3_ctrl and lc3_dp.
//
// Usage: each input transaction on s_axis is either a load (cmd 0: write one
// memory word, set pc to start_address, clear halt) or a step (cmd 1: run
// one instruction). Every input transaction yields exactly one result
// transaction on m_axis carrying status, OUT character, pc and flags.
// start_address is written through cfg_valid/cfg_ready/cfg_data; the user
// must write it only while idle, as the block itself does not enforce it.
// Sequence from the accepting edge to m_axis_tvalid: a step on a halted
// core goes straight to done, a load through load and done, a step through
// fetch, execute and done; LD/LDR add a memory state and LDI/STI an
// indirect and a memory state. The next input is taken in the cycle its
// result appears, so no new input is taken while one is in flight.
// A result is held in the output register until m_axis_tready; s_axis_tready
// stays low while a result waits, so a stalled receiver holds off the input.
// Reset (aresetn low, synchronous) clears registers, flags, halt and sets
// pc to 0x3000; memory contents stay undefined until loaded.
module lc3_processor_core import lc3_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: load_address[15:0], load_data[31:16], key_valid[32], key_char[40:33]
    input  logic [47:0] s_axis_tdata,
    // tuser: cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[1:0], out_valid[2], out_char[10:3], program_counter[26:11],
    // cond_flags[29:27]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     m_load, in_take;
    logic [15:0] start_reg;
    logic [1:0]  r_status;
    logic        r_ov;
    logic [7:0]  r_oc;
    logic [15:0] r_pc;
    logic [2:0]  r_flags;
    logic        mvalid_reg;
    logic [31:0] mdata_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) start_reg <= PC_RESET;
        else if (cfg_valid) start_reg <= cfg_data;
    end

    assign in_take = s_axis_tvalid && s_axis_tready;

    lc3_ctrl u_ctrl (
        .aclk, .aresetn,
        .s_valid(s_axis_tvalid), .s_cmd(s_axis_tuser), .s_ready(s_axis_tready),
        .m_busy(mvalid_reg && !m_axis_tready), .m_load, .stat, .cmd
    );

    lc3_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .in_take,
        .in_addr(s_axis_tdata[15:0]), .in_data(s_axis_tdata[31:16]),
        .in_key_valid(s_axis_tdata[32]), .in_key_char(s_axis_tdata[40:33]),
        .start_address(start_reg),
        .r_status, .r_out_valid(r_ov), .r_out_char(r_oc), .r_pc, .r_flags
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) mvalid_reg <= 1'b0;
        else if (m_load) mvalid_reg <= 1'b1;
        else if (m_axis_tready) mvalid_reg <= 1'b0;
        if (m_load) mdata_reg <= {2'd0, r_flags, r_pc, r_oc, r_ov, r_status};
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> (!mvalid_reg || m_axis_tready))
        else $error("result overwritten");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> !m_load)
        else $error("accept during reply");
    a_halt_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_load && r_status == ST_ILLEGAL) |-> stat.halted)
        else $error("illegal opcode without halt");

endmodule
